@@ rtl/core/cpit_pkg.sv @@
// ----------------------------------------------------------------------------
// cpit_pkg
// Shared types and constants for the colour palette intern table.
// ----------------------------------------------------------------------------
package cpit_pkg;

    localparam int RGB_W = 24;
    localparam int NUM_W = 8;

    // Command codes
    localparam logic CMD_INTERN = 1'b0;
    localparam logic CMD_READ   = 1'b1;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_SCAN = 4'b0010,
        S_RDBK = 4'b0100,
        S_DONE = 4'b1000
    } state_t;

endpackage

@@ rtl/core/colour_palette_intern_table_unit.sv @@
// An intern walks the filled entries in order and ends on a hit, an append or, on a full table,
// a refusal; a readback reads the addressed entry straight from the colour store.
// Throughput: one command at a time; the next beat is taken once the result is
// parked in the output register; the search walks the single read port of the colour store.
// Reset: synchronous active-low aresetn empties the table (fill count to zero);
// store contents are left as they are and never read before being written.
// ----------------------------------------------------------------------------
// colour_palette_intern_table_unit
// Interns 24-bit colours as logical colour numbers and reads them back.
// ----------------------------------------------------------------------------
module colour_palette_intern_table_unit #(
    parameter int FIRST_NUMBER = 16,
    parameter int NUMBER_COUNT = 256
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic                        s_cmd,
    input  logic [cpit_pkg::RGB_W-1:0]  s_rgb,
    input  logic [cpit_pkg::NUM_W-1:0]  s_colour_number,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic                        m_valid_res,
    output logic [cpit_pkg::NUM_W-1:0]  m_number_out,
    output logic [cpit_pkg::RGB_W-1:0]  m_rgb_out
);
    import cpit_pkg::*;

    localparam int CAP   = (NUMBER_COUNT > FIRST_NUMBER) ? NUMBER_COUNT - FIRST_NUMBER : 0;
    localparam int DEPTH = (CAP > 1) ? CAP : 2;
    localparam int AW    = $clog2(DEPTH);
    localparam int CW    = $clog2(DEPTH + 1);

    localparam logic [CW-1:0]    CAP_C   = CW'(CAP);
    localparam logic [NUM_W-1:0] FIRST_C = NUM_W'(FIRST_NUMBER);
    localparam logic [NUM_W:0]   COUNT_C = (NUM_W + 1)'(NUMBER_COUNT);

    state_t state_reg, state_next;

    logic [RGB_W-1:0] mem [DEPTH];
    logic [RGB_W-1:0] rd_data_reg;

    logic [CW-1:0]    fill_reg, fill_next;
    logic [CW-1:0]    idx_reg, idx_next;
    logic [AW-1:0]    cmp_idx_reg, cmp_idx_next;
    logic             rd_pend_reg, rd_pend_next;
    logic [RGB_W-1:0] rgb_reg, rgb_next;

    logic             res_valid_reg, res_valid_next;
    logic [NUM_W-1:0] res_num_reg, res_num_next;
    logic [RGB_W-1:0] res_rgb_reg, res_rgb_next;

    logic             m_valid_reg, m_valid_next;
    logic             m_valid_res_reg;
    logic [NUM_W-1:0] m_number_out_reg;
    logic [RGB_W-1:0] m_rgb_out_reg;

    logic             rd_en, wr_en;
    logic [AW-1:0]    rd_addr, wr_addr;
    logic             issue, hit, out_free, load_out;
    logic [NUM_W:0]   num_ext, k_wide;
    logic             rb_ok;

    assign s_ready      = (state_reg == S_IDLE);
    assign out_free     = !m_valid_reg || m_ready;
    assign load_out     = (state_reg == S_DONE) && out_free;
    assign m_valid      = m_valid_reg;
    assign m_valid_res  = m_valid_res_reg;
    assign m_number_out = m_number_out_reg;
    assign m_rgb_out    = m_rgb_out_reg;

    // Readback range check on the incoming beat
    assign num_ext = {1'b0, s_colour_number};
    assign k_wide  = num_ext - {1'b0, FIRST_C};
    assign rb_ok   = (s_colour_number >= FIRST_C) && (num_ext < COUNT_C)
                     && (k_wide < (NUM_W + 1)'(fill_reg));

    assign issue = (idx_reg < fill_reg);
    assign hit   = rd_pend_reg && (rd_data_reg == rgb_reg);

    always_comb begin
        state_next     = state_reg;
        fill_next      = fill_reg;
        idx_next       = idx_reg;
        cmp_idx_next   = cmp_idx_reg;
        rd_pend_next   = 1'b0;
        rgb_next       = rgb_reg;
        res_valid_next = res_valid_reg;
        res_num_next   = res_num_reg;
        res_rgb_next   = res_rgb_reg;
        rd_en          = 1'b0;
        rd_addr        = idx_reg[AW-1:0];
        wr_en          = 1'b0;
        wr_addr        = fill_reg[AW-1:0];

        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    rgb_next = s_rgb;
                    idx_next = '0;
                    if (s_cmd == CMD_READ) begin
                        rd_en          = rb_ok;
                        rd_addr        = k_wide[AW-1:0];
                        res_valid_next = rb_ok;
                        res_num_next   = rb_ok ? s_colour_number : '0;
                        state_next     = S_RDBK;
                    end else begin
                        state_next = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                if (hit) begin
                    res_valid_next = 1'b1;
                    res_num_next   = FIRST_C + NUM_W'(cmp_idx_reg);
                    res_rgb_next   = rgb_reg;
                    state_next     = S_DONE;
                end else if (issue) begin
                    // read the next entry; compare it in the following cycle
                    rd_en        = 1'b1;
                    rd_pend_next = 1'b1;
                    cmp_idx_next = idx_reg[AW-1:0];
                    idx_next     = idx_reg + 1'b1;
                end else if (fill_reg < CAP_C) begin
                    // miss with room left: append
                    wr_en          = 1'b1;
                    fill_next      = fill_reg + 1'b1;
                    res_valid_next = 1'b1;
                    res_num_next   = FIRST_C + NUM_W'(fill_reg);
                    res_rgb_next   = rgb_reg;
                    state_next     = S_DONE;
                end else begin
                    res_valid_next = 1'b0;
                    res_num_next   = '0;
                    res_rgb_next   = '0;
                    state_next     = S_DONE;
                end
            end
            S_RDBK: begin
                res_rgb_next = res_valid_reg ? rd_data_reg : '0;
                state_next   = S_DONE;
            end
            S_DONE: begin
                if (out_free) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (load_out) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    // Colour store: one write and one registered read per cycle
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= rgb_reg;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            fill_reg    <= '0;
            rd_pend_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            fill_reg    <= fill_next;
            rd_pend_reg <= rd_pend_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        idx_reg       <= idx_next;
        cmp_idx_reg   <= cmp_idx_next;
        rgb_reg       <= rgb_next;
        res_valid_reg <= res_valid_next;
        res_num_reg   <= res_num_next;
        res_rgb_reg   <= res_rgb_next;
        if (load_out) begin
            m_valid_res_reg  <= res_valid_reg;
            m_number_out_reg <= res_num_reg;
            m_rgb_out_reg    <= res_rgb_reg;
        end
    end

    // ------------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------------
    a_fill_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        fill_reg <= CAP_C)
        else $error("fill count beyond capacity");

    a_fill_step: assert property (@(posedge aclk) disable iff (!aresetn)
        ($past(aresetn) && (fill_reg != $past(fill_reg)))
            |-> (fill_reg == $past(fill_reg) + 1'b1))
        else $error("fill count moved by other than one");

    a_cmp_filled: assert property (@(posedge aclk) disable iff (!aresetn)
        rd_pend_reg |-> (CW'(cmp_idx_reg) < fill_reg))
        else $error("compare of an unfilled entry");

    a_fail_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_valid_res) |-> ((m_number_out == '0) && (m_rgb_out == '0)))
        else $error("failed result carries nonzero payload");

    a_num_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_valid_res)
            |-> ((m_number_out >= FIRST_C) && ({1'b0, m_number_out} < COUNT_C)))
        else $error("result number outside the table range");

endmodule

@@ verif/colour_palette_intern_table_unit_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// colour_palette_intern_table_unit_tb
// Self-checking bench for the palette intern table. Directed commands cover
// both colour extremes, hits, appends and readbacks of numbers outside the
// table. Random traffic then fills the table, keeps interning past full, and
// mixes in readbacks. Both channels see random idle cycles. A scoreboard
// predicts every result beat and compares it field by field.
// ----------------------------------------------------------------------------
module colour_palette_intern_table_unit_tb;
    import cpit_pkg::*;

    localparam int FIRST_NUMBER = 16;
    localparam int NUMBER_COUNT = 256;
    localparam int CAPACITY     = NUMBER_COUNT - FIRST_NUMBER;
    localparam int RANDOM_BEATS = 530;
    localparam int CYCLE_LIMIT  = 1000000;
    localparam int IDLE_PCT     = 6;

    typedef struct packed {
        logic             ok;
        logic [NUM_W-1:0] number;
        logic [RGB_W-1:0] rgb;
    } palette_result_t;

    class palette_scoreboard;
        logic [RGB_W-1:0] palette [CAPACITY];
        int               filled;
        palette_result_t  awaited [$];
        int               errors;
        int               hits, appends, refusals, reads_ok, reads_bad;

        function new();
            filled = 0;
            errors = 0;
            hits = 0;
            appends = 0;
            refusals = 0;
            reads_ok = 0;
            reads_bad = 0;
        endfunction

        function int pending();
            return awaited.size();
        endfunction

        task report(input string msg);
            errors++;
            $display("MISMATCH at %0t: %s", $realtime, msg);
        endtask

        // Intern searches filled entries first, then appends if room is left.
        function void note_beat(input logic cmd, input logic [RGB_W-1:0] rgb,
                                input logic [NUM_W-1:0] num);
            palette_result_t r;
            int              idx;
            int              k;
            r   = '0;
            idx = -1;
            if (cmd == CMD_INTERN) begin
                for (k = 0; k < filled; k++) begin
                    if (palette[k] == rgb) begin
                        idx = k;
                        break;
                    end
                end
                if (idx >= 0) begin
                    hits++;
                end else if (filled < CAPACITY) begin
                    palette[filled] = rgb;
                    idx = filled;
                    filled++;
                    appends++;
                end else begin
                    refusals++;
                end
                if (idx >= 0)
                    r = '{1'b1, NUM_W'(FIRST_NUMBER + idx), rgb};
            end else begin
                if (int'(num) >= FIRST_NUMBER && int'(num) < NUMBER_COUNT &&
                    int'(num) - FIRST_NUMBER < filled) begin
                    r = '{1'b1, num, palette[int'(num) - FIRST_NUMBER]};
                    reads_ok++;
                end else begin
                    reads_bad++;
                end
            end
            awaited.push_back(r);
        endfunction

        task check_result(input logic ok, input logic [NUM_W-1:0] num,
                          input logic [RGB_W-1:0] rgb);
            palette_result_t want;
            if (awaited.size() == 0) begin
                report($sformatf("unexpected beat valid_res=%0b number=%0d rgb=%06h",
                                 ok, num, rgb));
                return;
            end
            want = awaited.pop_front();
            if (ok !== want.ok)
                report($sformatf("valid_res %0b, want %0b", ok, want.ok));
            if (num !== want.number)
                report($sformatf("number_out %0d, want %0d", num, want.number));
            if (rgb !== want.rgb)
                report($sformatf("rgb_out %06h, want %06h", rgb, want.rgb));
        endtask
    endclass

    logic               aclk            = 1'b0;
    logic               aresetn         = 1'b0;
    logic               s_valid         = 1'b0;
    logic               s_ready;
    logic               s_cmd           = CMD_INTERN;
    logic [RGB_W-1:0]   s_rgb           = '0;
    logic [NUM_W-1:0]   s_colour_number = '0;
    logic               m_valid;
    logic               m_ready         = 1'b0;
    logic               m_valid_res;
    logic [NUM_W-1:0]   m_number_out;
    logic [RGB_W-1:0]   m_rgb_out;

    palette_scoreboard  sb = new();
    bit                 quiet = 1'b0;
    int                 cycle_count = 0;

    colour_palette_intern_table_unit #(
        .FIRST_NUMBER (FIRST_NUMBER),
        .NUMBER_COUNT (NUMBER_COUNT)
    ) dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_cmd           (s_cmd),
        .s_rgb           (s_rgb),
        .s_colour_number (s_colour_number),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_valid_res     (m_valid_res),
        .m_number_out    (m_number_out),
        .m_rgb_out       (m_rgb_out)
    );

    always #1 aclk = ~aclk;

    always @(posedge aclk) begin
        m_ready <= quiet || ($urandom_range(99) >= IDLE_PCT);
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready)
                sb.note_beat(s_cmd, s_rgb, s_colour_number);
            if (m_valid && m_ready)
                sb.check_result(m_valid_res, m_number_out, m_rgb_out);
        end
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles, %0d beats outstanding",
                     cycle_count, sb.pending());
            $display("*** FAILED ***");
            $finish;
        end
    end

    task automatic send_beat(input logic cmd, input logic [RGB_W-1:0] rgb,
                             input logic [NUM_W-1:0] num);
        if (!quiet && $urandom_range(99) < IDLE_PCT) begin
            s_valid <= 1'b0;
            @(posedge aclk);
            while ($urandom_range(99) < 50) @(posedge aclk);
        end
        s_valid         <= 1'b1;
        s_cmd           <= cmd;
        s_rgb           <= rgb;
        s_colour_number <= num;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    // Hold the input channel until every expected beat has come back.
    task automatic hold_until_drained();
        s_valid <= 1'b0;
        do @(posedge aclk); while (sb.pending() != 0);
    endtask

    initial begin
        int               n;
        int               pick;
        logic [RGB_W-1:0] rgb;
        logic [NUM_W-1:0] num;

        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: empty table, colour extremes, hits, out-of-table numbers.
        send_beat(CMD_READ,   24'hffffff, 8'd16);
        send_beat(CMD_INTERN, 24'h000000, 8'd255);
        send_beat(CMD_INTERN, 24'hffffff, 8'd0);
        send_beat(CMD_INTERN, 24'h000000, 8'd0);
        send_beat(CMD_INTERN, 24'hffffff, 8'd255);
        send_beat(CMD_READ,   24'h000000, 8'd16);
        send_beat(CMD_READ,   24'hffffff, 8'd17);
        send_beat(CMD_READ,   24'h000000, 8'd18);
        send_beat(CMD_READ,   24'h000000, 8'd0);
        send_beat(CMD_READ,   24'hffffff, 8'd15);
        send_beat(CMD_READ,   24'h000000, 8'd255);
        send_beat(CMD_INTERN, 24'haa55aa, 8'haa);
        send_beat(CMD_INTERN, 24'h55aa55, 8'h55);
        send_beat(CMD_INTERN, 24'h000001, 8'd1);
        send_beat(CMD_INTERN, 24'h800000, 8'd128);
        send_beat(CMD_INTERN, 24'h55aa55, 8'd0);
        send_beat(CMD_READ,   24'h123456, 8'd19);
        send_beat(CMD_READ,   24'h654321, 8'd20);
        send_beat(CMD_READ,   24'h000000, 8'd22);
        send_beat(CMD_INTERN, 24'h000001, 8'd7);
        hold_until_drained();

        for (n = 0; n < RANDOM_BEATS; n++) begin
            quiet = (n >= 150 && n < 260);
            if (n == 320 || $urandom_range(199) == 0)
                hold_until_drained();
            pick = $urandom_range(99);
            rgb  = RGB_W'($urandom());
            num  = NUM_W'($urandom());
            if (pick < 60 || sb.filled == 0) begin
                send_beat(CMD_INTERN, rgb, num);
            end else if (pick < 80) begin
                rgb = sb.palette[$urandom_range(sb.filled - 1)];
                send_beat(CMD_INTERN, rgb, num);
            end else if (pick < 92) begin
                num = NUM_W'(FIRST_NUMBER + $urandom_range(sb.filled - 1));
                send_beat(CMD_READ, rgb, num);
            end else begin
                send_beat(CMD_READ, rgb, num);
            end
        end
        s_valid <= 1'b0;

        do @(posedge aclk); while (sb.pending() != 0);
        repeat (8) @(posedge aclk);

        $display("Interns: %0d found, %0d appended, %0d refused on a full table (%0d filled)",
                 sb.hits, sb.appends, sb.refusals, sb.filled);
        $display("Readbacks: %0d valid, %0d invalid; %0d mismatches",
                 sb.reads_ok, sb.reads_bad, sb.errors);
        if (sb.errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

@@ filelist.f @@
rtl/core/cpit_pkg.sv
rtl/core/colour_palette_intern_table_unit.sv
verif/colour_palette_intern_table_unit_tb.sv
